### design/hlfd_pkg.sv
package hlfd_pkg;

   // header and command codes
   localparam logic [7:0] HDR_FIRST   = 8'hEB;
   localparam logic [7:0] HDR_SECOND  = 8'h53;
   localparam logic [7:0] CMD_UPGRADE = 8'h35;
   localparam logic [7:0] CMD_EXPORT  = 8'h33;

   localparam int COUNT_W  = 17;
   localparam int LENGTH_W = 16;

   // frame positions inside the body
   localparam logic [COUNT_W-1:0] POS_LEN_LO  = 17'd2;
   localparam logic [COUNT_W-1:0] POS_LEN_HI  = 17'd3;
   localparam logic [COUNT_W-1:0] POS_COMMAND = 17'd4;
   localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd5;

   // result queue between parser and output stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HEAD = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_UPGRADE = 2'd0,
      KIND_EXPORT  = 2'd1,
      KIND_OTHER   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0]         data_byte;
      logic               in_frame;
      logic               frame_end;
      kind_type           frame_kind;
      logic [COUNT_W-1:0] frame_length;
      logic               checksum_ok;
      logic               header_abort;
   } rsp_item_type;

endpackage

### design/hlfd_front.sv
module hlfd_front
   import hlfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_valid,
   input  logic [7:0]   rx_byte,
   output rsp_item_type item
);

   phase_type             phase_ff, phase_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [7:0]            command_ff, command_in;
   logic [7:0]            xor_ff, xor_in;

   logic [COUNT_W-1:0]    count_next;
   logic [LENGTH_W-1:0]   length_now;
   logic [7:0]            command_now;
   logic [7:0]            xor_now;
   logic                  body_end;
   kind_type              kind_now;

   // body-side values as they stand after this byte
   always_comb begin
      count_next  = count_ff + 17'd1;
      length_now  = length_ff;
      command_now = command_ff;
      if (count_ff == POS_LEN_LO) begin
         length_now = {length_ff[15:8], rx_byte};
      end else if (count_ff == POS_LEN_HI) begin
         length_now = {rx_byte, length_ff[7:0]};
      end
      if (count_ff == POS_COMMAND) begin
         command_now = rx_byte;
      end
      xor_now  = xor_ff ^ rx_byte;
      body_end = (count_next >= FRAME_OVERHEAD) &&
                 (count_next == ({1'b0, length_now} + FRAME_OVERHEAD));
   end

   always_comb begin
      unique case (command_now)
         CMD_UPGRADE: kind_now = KIND_UPGRADE;
         CMD_EXPORT:  kind_now = KIND_EXPORT;
         default:     kind_now = KIND_OTHER;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      command_in = command_ff;
      xor_in     = xor_ff;

      item              = '0;
      item.data_byte    = rx_byte;
      item.frame_kind   = KIND_UPGRADE;

      unique case (phase_ff)
         PH_HEAD: begin
            if (rx_byte == HDR_SECOND) begin
               phase_in      = PH_BODY;
               count_in      = 17'd2;
               xor_in        = rx_byte;
               item.in_frame = 1'b1;
            end else begin
               phase_in          = PH_IDLE;
               count_in          = '0;
               length_in         = '0;
               command_in        = '0;
               xor_in            = '0;
               item.header_abort = 1'b1;
            end
         end
         PH_BODY: begin
            item.in_frame = 1'b1;
            if (body_end) begin
               phase_in          = PH_IDLE;
               count_in          = '0;
               length_in         = '0;
               command_in        = '0;
               xor_in            = '0;
               item.frame_end    = 1'b1;
               item.frame_kind   = kind_now;
               item.frame_length = count_next;
               item.checksum_ok  = (xor_now == 8'h00);
            end else begin
               count_in   = count_next;
               length_in  = length_now;
               command_in = command_now;
               xor_in     = xor_now;
            end
         end
         default: begin
            // idle, hunting the first header byte
            phase_in   = PH_IDLE;
            count_in   = '0;
            length_in  = '0;
            command_in = '0;
            xor_in     = '0;
            if (rx_byte == HDR_FIRST) begin
               phase_in      = PH_HEAD;
               count_in      = 17'd1;
               item.in_frame = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         length_ff  <= '0;
         command_ff <= '0;
         xor_ff     <= '0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         xor_ff     <= xor_in;
      end
   end

endmodule

### design/hlfd_queue.sv
module hlfd_queue
   import hlfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output rsp_item_type head_item
);

   localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

   rsp_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/hlfd_back.sv
module hlfd_back
   import hlfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  rsp_item_type head_item,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // refill the output register whenever it is empty or being drained
   assign pop      = head_valid && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### design/header_length_frame_deframer_unit.sv
// frame parser for a received byte stream with header 0xEB 0x53
// req channel: one received byte per beat in req_tdata[7:0]
// rsp channel: exactly one beat per accepted byte, in order; the byte is passed
//    through with its frame marks; rsp_tlast flags the byte that closes a frame,
//    and only on that beat do kind, total length and checksum status carry values
// a mismatched second header byte drops the partial frame and raises header_abort
// with an idle receiver an accepted byte is first written into the queue and
//    then into the output register, which drives rsp_tvalid
// throughput: one byte per cycle, sustained while the receiver does not stall;
//    the parser state updates once per byte, so a byte can follow the previous one directly
// the parser writes each result into a two-entry queue; an output register
//    drains it, so a stalled receiver fills the queue and only then drops
//    req_tready; no beat is lost or repeated while stalled
// reset: synchronous, active high; the parser returns to header hunt and the
//    queue and output register are emptied
module header_length_frame_deframer_unit
   import hlfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [8] in_frame, [10:9] frame_kind,
                                    // [27:11] frame_length, [28] checksum_ok,
                                    // [29] header_abort, [31:30] zero
   output logic        rsp_tlast    // frame_end
);

   logic         push;
   logic         queue_full;
   logic         pop;
   logic         head_valid;
   rsp_item_type front_item;
   rsp_item_type head_item;
   rsp_item_type out_item;

   // a byte is taken whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // parser: header hunt, length and command capture, running xor
   hlfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (push),
      .rx_byte    (req_tdata),
      .item       (front_item)
   );

   // decouples the parser from receiver stalls
   hlfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // output register on the rsp side
   hlfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   // beat packing, lowest field first
   assign rsp_tdata = {2'b00,
                       out_item.header_abort,
                       out_item.checksum_ok,
                       out_item.frame_length,
                       out_item.frame_kind,
                       out_item.in_frame,
                       out_item.data_byte};
   assign rsp_tlast = out_item.frame_end;

endmodule
